// File: sv/message_match_queue_unit_assert.svh
// Assertion macros for the message match queue unit.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MESSAGE_MATCH_QUEUE_UNIT_ASSERT_SVH
`define MESSAGE_MATCH_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication under synchronous active-low reset
`define MMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("message_match_queue_unit: check failed");
// next-cycle implication under synchronous active-low reset
`define MMQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("message_match_queue_unit: check failed");
`else
`define MMQ_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MMQ_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: sv/mmq_pkg.sv
// Shared types and constants for the message match queue unit.
// No dependencies.
package mmq_pkg;

  // Stream widths
  localparam int unsigned ENV_W   = 74;
  localparam int unsigned TDATA_W = 80;

  // Request kinds carried on in_tuser
  localparam logic KIND_ARRIVAL = 1'b0;
  localparam logic KIND_SEARCH  = 1'b1;

  // Result status carried on out_tuser
  localparam logic [1:0] ST_QUEUED   = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_HIT      = 2'd2;
  localparam logic [1:0] ST_NO_MATCH = 2'd3;

  // Envelope key, communicator in the lowest bits
  typedef struct packed {
    logic        tag_any;
    logic [15:0] tag;
    logic        source_any;
    logic [7:0]  source;
    logic [7:0]  target;
    logic [7:0]  comm;
  } key_t;

  // Stored envelope: key below payload, same layout as tdata
  typedef struct packed {
    logic [31:0] payload;
    key_t        key;
  } env_t;

  // Exact communicator and target, wildcard-aware source and tag
  function automatic logic keys_match(input key_t pat, input key_t ent);
    logic src_ok;
    logic tag_ok;
    src_ok = pat.source_any | ent.source_any | (pat.source == ent.source);
    tag_ok = pat.tag_any | ent.tag_any | (pat.tag == ent.tag);
    return (pat.comm == ent.comm) && (pat.target == ent.target) && src_ok && tag_ok;
  endfunction

endpackage

// File: sv/message_match_queue_unit.sv
// Top level of the message match queue: ordered envelope queue with match-and-remove.
// Depends on mmq_pkg, mmq_ram and message_match_queue_unit_assert.svh.
`include "message_match_queue_unit_assert.svh"

// Envelopes are held in arrival order as a linked list over QUEUE_DEPTH slots in two
// RAMs: one holds the envelope (key and payload), the other the next-slot links, which
// also thread the list of freed slots. Slots are first handed out by a fill counter,
// so no clearing pass follows reset and requests are taken right away. An arrival
// (in_tuser = 0) that reuses a freed slot also passes through S_ALLOC to read back the
// free-list link. A search (in_tuser = 1) reads one queued entry per cycle from the
// envelope RAM starting at the oldest: it issues the first read, visits the entries in
// S_WALK and, on a hit, returns the slot to the free list in S_UNLINK. A one-deep
// result buffer ahead of the output register lets a new request be taken while a
// result still waits on out_tready. Every request gives exactly one result; out_tuser
// carries its status.
module message_match_queue_unit #(
  parameter int unsigned QUEUE_DEPTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata, low to high: comm_id[7:0], target_rank[15:8], source_rank[23:16],
  // source_any[24], tag_value[40:25], tag_any[41], payload_word[73:42], zero pad
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mmq_pkg::TDATA_W-1:0] in_tdata,
  // in_tuser: kind[0]
  input  logic                       in_tuser,
  // out_tdata, low to high: hit_comm_id[7:0], hit_target[15:8], hit_source[23:16],
  // hit_source_any[24], hit_tag[40:25], hit_tag_any[41], hit_payload[73:42], zero pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mmq_pkg::TDATA_W-1:0] out_tdata,
  // out_tuser: status[1:0]
  output logic [1:0]                 out_tuser
);

  import mmq_pkg::*;

  localparam int unsigned IW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  // Sequencer states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ALLOC  = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_UNLINK = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [IW-1:0] tail_r, tail_nxt;
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [IW-1:0] cur_r, cur_nxt;
  logic [IW-1:0] prev_r, prev_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic [IW-1:0] walk_n_r, walk_n_nxt;
  key_t          pat_r, pat_nxt;

  logic          res_valid_r, res_valid_nxt;
  logic [1:0]    res_status_r, res_status_nxt;
  env_t          res_env_r, res_env_nxt;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  env_t          out_env_r;

  logic          ent_we;
  logic [IW-1:0] ent_waddr, ent_raddr;
  env_t          ent_wdata;
  logic [ENV_W-1:0] ent_rdata_raw;
  env_t          ent_rdata;
  logic          lnk_we;
  logic [IW-1:0] lnk_waddr, lnk_raddr, lnk_wdata, lnk_rdata;

  logic          in_fire;
  logic          res_move;
  logic          fill_open;
  logic [IW-1:0] new_slot;
  env_t          in_env;

  assign in_env    = env_t'(in_tdata[ENV_W-1:0]);
  assign in_tready = (state_r == S_IDLE) && !res_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign res_move  = res_valid_r && (!out_valid_r || out_tready);
  assign fill_open = (fill_r < DEPTH_C);
  assign new_slot  = fill_open ? fill_r[IW-1:0] : free_head_r;
  assign ent_rdata = env_t'(ent_rdata_raw);

  // Envelope store
  mmq_ram #(.WIDTH(ENV_W), .DEPTH(QUEUE_DEPTH)) u_env_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata_raw)
  );

  // Next-slot links for the queue and the free list
  mmq_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_link_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (lnk_raddr),
    .rdata (lnk_rdata)
  );

  // Sequencer: append, walk, unlink
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    free_head_nxt  = free_head_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    have_prev_nxt  = have_prev_r;
    walk_n_nxt     = walk_n_r;
    pat_nxt        = pat_r;
    res_status_nxt = res_status_r;
    res_env_nxt    = res_env_r;
    res_valid_nxt  = res_valid_r && !res_move;
    ent_we         = 1'b0;
    ent_waddr      = new_slot;
    ent_wdata      = in_env;
    ent_raddr      = head_r;
    lnk_we         = 1'b0;
    lnk_waddr      = tail_r;
    lnk_wdata      = new_slot;
    lnk_raddr      = free_head_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_env_nxt   = '0;
          res_valid_nxt = 1'b1;
          if (in_tuser == KIND_ARRIVAL) begin
            if (count_r == DEPTH_C) begin
              res_status_nxt = ST_FULL;
            end else begin
              // append at the tail
              res_status_nxt = ST_QUEUED;
              ent_we         = 1'b1;
              if (count_r != '0) begin
                lnk_we = 1'b1;
              end else begin
                head_nxt = new_slot;
              end
              tail_nxt  = new_slot;
              count_nxt = count_r + CW'(1);
              if (fill_open) begin
                fill_nxt = fill_r + CW'(1);
              end else begin
                // pop the free list; its next link arrives next cycle
                state_nxt = S_ALLOC;
              end
            end
          end else begin
            pat_nxt = in_env.key;
            if (count_r == '0) begin
              res_status_nxt = ST_NO_MATCH;
            end else begin
              // start at the oldest entry
              res_valid_nxt = 1'b0;
              ent_raddr     = head_r;
              lnk_raddr     = head_r;
              cur_nxt       = head_r;
              have_prev_nxt = 1'b0;
              walk_n_nxt    = '0;
              state_nxt     = S_WALK;
            end
          end
        end
      end

      S_ALLOC: begin
        free_head_nxt = lnk_rdata;
        state_nxt     = S_IDLE;
      end

      S_WALK: begin
        if (keys_match(pat_r, ent_rdata.key)) begin
          // hit: bypass the entry
          res_status_nxt = ST_HIT;
          res_env_nxt    = ent_rdata;
          res_valid_nxt  = 1'b1;
          if (have_prev_r) begin
            lnk_we    = 1'b1;
            lnk_waddr = prev_r;
            lnk_wdata = lnk_rdata;
          end else begin
            head_nxt = lnk_rdata;
          end
          if (cur_r == tail_r) begin
            tail_nxt = have_prev_r ? prev_r : '0;
          end
          count_nxt = count_r - CW'(1);
          state_nxt = S_UNLINK;
        end else if (CW'(walk_n_r) + CW'(1) == count_r) begin
          res_status_nxt = ST_NO_MATCH;
          res_env_nxt    = '0;
          res_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          // advance to the next entry
          ent_raddr     = lnk_rdata;
          lnk_raddr     = lnk_rdata;
          prev_nxt      = cur_r;
          cur_nxt       = lnk_rdata;
          have_prev_nxt = 1'b1;
          walk_n_nxt    = walk_n_r + IW'(1);
        end
      end

      S_UNLINK: begin
        // push the freed slot on the free list
        lnk_we        = 1'b1;
        lnk_waddr     = cur_r;
        lnk_wdata     = free_head_r;
        free_head_nxt = cur_r;
        state_nxt     = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      fill_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      free_head_r <= '0;
      have_prev_r <= 1'b0;
      walk_n_r    <= '0;
      res_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      free_head_r <= free_head_nxt;
      have_prev_r <= have_prev_nxt;
      walk_n_r    <= walk_n_nxt;
      res_valid_r <= res_valid_nxt;
      if (res_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    pat_r        <= pat_nxt;
    res_status_r <= res_status_nxt;
    res_env_r    <= res_env_nxt;
    if (res_move) begin
      out_status_r <= res_status_r;
      out_env_r    <= res_env_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(TDATA_W - ENV_W){1'b0}}, out_env_r};

  // Checks
  `MMQ_ASSERT_IMP(a_count_le_fill, clk, rst_n, 1'b1, count_r <= fill_r)
  `MMQ_ASSERT_NXT(a_req_progress, clk, rst_n, in_fire, res_valid_r || state_r == S_WALK)
  `MMQ_ASSERT_IMP(a_walk_bound, clk, rst_n, state_r == S_WALK, CW'(walk_n_r) < count_r)
  `MMQ_ASSERT_NXT(a_unlink_idle, clk, rst_n, state_r == S_UNLINK, state_r == S_IDLE)
  `MMQ_ASSERT_NXT(a_hit_unlinks, clk, rst_n, state_r == S_UNLINK, res_valid_r || out_valid_r)

endmodule

// File: sv/mmq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
